// File: design/cmdd_pkg.sv
// Shared types, codes and constants for the CSR command decoder.
// No dependencies; every other design file imports this package.
`default_nettype none

package cmdd_pkg;

	localparam int DEF_DEVICE_NUMBER = 0;
	localparam int DEF_BEAT_BYTES    = 32;

	localparam int REG_WORDS = 7;
	localparam int WIDX_W    = 3;
	localparam int READ_STEPS = 5;

	localparam logic [WIDX_W-1:0] WIDX_RES   = 3'd1;
	localparam logic [WIDX_W-1:0] WIDX_IN    = 3'd2;
	localparam logic [WIDX_W-1:0] WIDX_MODE  = 3'd3;
	localparam logic [WIDX_W-1:0] WIDX_STEP  = 3'd4;
	localparam logic [WIDX_W-1:0] WIDX_OUT   = 3'd5;
	localparam logic [WIDX_W-1:0] WIDX_START = 3'd6;
	localparam logic [WIDX_W-1:0] WIDX_NONE  = 3'd7;

	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_IGNORED  = 3'd1;
	localparam logic [2:0] STATUS_WRONGDEV = 3'd2;
	localparam logic [2:0] STATUS_ORDER    = 3'd3;
	localparam logic [2:0] STATUS_IDX7     = 3'd4;

	localparam logic [1:0] VERDICT_NONE     = 2'd0;
	localparam logic [1:0] VERDICT_TIMED    = 2'd1;
	localparam logic [1:0] VERDICT_UNTIMED  = 2'd2;
	localparam logic [1:0] VERDICT_REJECTED = 2'd3;

	localparam logic [1:0] TRANS_ONE  = 2'd1;
	localparam logic [1:0] TRANS_TWO  = 2'd2;
	localparam logic [1:0] FLOWM_MAX  = 2'd2;
	localparam logic [1:0] REUSE_ONE  = 2'd1;
	localparam logic [1:0] REGM_BAD   = 2'd2;

	localparam int OP_SET  = 0;
	localparam int OP_HOLD = 1;

	typedef struct packed {
		logic        accepted;
		logic [1:0]  req_type;
		logic [7:0]  bus_address;
		logic [63:0] write_data;
		logic [63:0] write_cycle;
	} cmd_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        command_start;
		logic [31:0] command_number;
		logic [1:0]  verdict;
		logic [19:0] resident_beats;
		logic [17:0] input_beats;
		logic [17:0] output_beats;
		logic [23:0] work_items;
		logic [20:0] flow_stride;
		logic [28:0] instr_stride;
	} cmd_rsp_t;

	// Sequencing of the datapath by the controller.
	typedef struct packed {
		logic              cap;
		logic [WIDX_W-1:0] tag;
		logic              mul1;
		logic              mul2;
		logic              mul3;
	} calc_ctl_t;

	// Register word fetched at each read step of a launch.
	function automatic logic [WIDX_W-1:0] word_of_step(input logic [2:0] step);
		logic [WIDX_W-1:0] w;
		case (step)
			3'd0: w = WIDX_MODE;
			3'd1: w = WIDX_RES;
			3'd2: w = WIDX_IN;
			3'd3: w = WIDX_OUT;
			3'd4: w = WIDX_STEP;
			default: w = WIDX_MODE;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: design/accel_csr_command_decoder_top.sv
// Top level of the CSR command decoder: handshakes, write checks, start latch and sequencer.
// Depends on cmdd_pkg, cmdd_regfile and cmdd_calc.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  cmd_req_t, one bus write
// rsp       out        rsp_valid / rsp_stall  cmd_rsp_t, one status per write
//
// A request that launches no command passes through the accept cycle (checks, register
// word write, start latch) and the cycle that loads the output register. A launching request
// passes through the accept cycle, five register word reads, a drain state for the last read
// data, three multiply stages and the output cycle. Reset clears the register words, the start
// latch, the stamps and the command count. A stalled response holds the output register; the
// next request is taken, and its response waits until the register frees.
module accel_csr_command_decoder_top
	import cmdd_pkg::*;
#(
	parameter int DEVICE_NUMBER = DEF_DEVICE_NUMBER,
	parameter int BEAT_BYTES    = DEF_BEAT_BYTES
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output      logic     req_stall,
	input  wire cmd_req_t req,
	output      logic     rsp_valid,
	input  wire logic     rsp_stall,
	output      cmd_rsp_t rsp
);

	localparam logic [3:0] DEV = 4'(DEVICE_NUMBER);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_DRAIN = 7'b0000100,
		S_MUL1  = 7'b0001000,
		S_MUL2  = 7'b0010000,
		S_MUL3  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// Architectural state kept in flops next to the memory.
	logic        latch_q;
	logic        seen_q;
	logic [63:0] start_stamp_q;
	logic [63:0] last_stamp_q;
	logic [31:0] count_q;

	// Response being built for the current request.
	logic [2:0]  status_q;
	logic        launch_q;

	logic [2:0]        rd_cnt_q;
	logic              rcap_s1;
	logic [WIDX_W-1:0] rtag_s1;

	logic     rsp_valid_q;
	cmd_rsp_t rsp_q;
	cmd_rsp_t rsp_d;

	logic              take;
	logic              rsp_free;
	logic              applied;
	logic [WIDX_W-1:0] idx;
	logic              latch_eff;
	logic              b31;
	logic              latch_next;
	logic              launch;
	logic              wr_en;
	logic              rd_en;
	logic [WIDX_W-1:0] rd_addr;
	logic [63:0]       rd_data;
	calc_ctl_t         ctl;

	logic [1:0]  c_verdict;
	logic [19:0] c_res;
	logic [17:0] c_inb, c_outb;
	logic [23:0] c_work;
	logic [20:0] c_fs;
	logic [28:0] c_is;

	assign req_stall = (state_q != S_IDLE);
	assign take      = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// The write checks of one request: ignored, other device, stamp going backwards.
	always_comb begin
		idx        = req.bus_address[3:1];
		applied    = req.accepted && (req.bus_address[7:4] == DEV) &&
			!(seen_q && (req.write_cycle < last_stamp_q));
		// A later stamp than the launch stamp drops the latch before this write acts.
		latch_eff  = latch_q && !(req.write_cycle > start_stamp_q);
		b31        = req.write_data[31];
		latch_next = (req.req_type[OP_SET] && (latch_eff || b31)) ||
			(req.req_type[OP_HOLD] && latch_eff && b31);
		launch     = applied && (idx == WIDX_START) && !latch_eff && latch_next;
		wr_en      = take && applied && (idx != WIDX_NONE);
	end

	// Reads happen only while the block holds off requests, and writes only in the
	// accept cycle, so the two ports never touch the memory in the same cycle.
	assign rd_en   = (state_q == S_READ);
	assign rd_addr = word_of_step(rd_cnt_q);

	always_comb begin
		ctl.cap  = rcap_s1;
		ctl.tag  = rtag_s1;
		ctl.mul1 = (state_q == S_MUL1);
		ctl.mul2 = (state_q == S_MUL2);
		ctl.mul3 = (state_q == S_MUL3);
	end

	cmdd_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (idx),
		.wr_data (req.write_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cmdd_calc #(
		.BEAT_BYTES (BEAT_BYTES)
	) u_calc (
		.clk            (clk),
		.ctl            (ctl),
		.rd_data        (rd_data),
		.verdict        (c_verdict),
		.resident_beats (c_res),
		.input_beats    (c_inb),
		.output_beats   (c_outb),
		.work_items     (c_work),
		.flow_stride    (c_fs),
		.instr_stride   (c_is)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			latch_q       <= 1'b0;
			seen_q        <= 1'b0;
			start_stamp_q <= '0;
			last_stamp_q  <= '0;
			count_q       <= '0;
			status_q      <= STATUS_OK;
			launch_q      <= 1'b0;
			rd_cnt_q      <= '0;
			rcap_s1       <= 1'b0;
			rtag_s1       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			rcap_s1 <= rd_en;
			rtag_s1 <= rd_addr;
			// The output register loads when it is free; otherwise it empties on a take.
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						launch_q <= launch;
						rd_cnt_q <= '0;
						state_q  <= launch ? S_READ : S_DONE;
						if (!req.accepted) begin
							status_q <= STATUS_IGNORED;
						end else if (req.bus_address[7:4] != DEV) begin
							status_q <= STATUS_WRONGDEV;
						end else if (!applied) begin
							status_q <= STATUS_ORDER;
						end else begin
							seen_q       <= 1'b1;
							last_stamp_q <= req.write_cycle;
							if (idx == WIDX_NONE) begin
								status_q <= STATUS_IDX7;
								latch_q  <= latch_eff;
							end else if (idx != WIDX_START) begin
								status_q <= STATUS_OK;
								latch_q  <= latch_eff;
							end else begin
								status_q <= STATUS_OK;
								latch_q  <= latch_next;
								if (launch) begin
									start_stamp_q <= req.write_cycle;
									count_q       <= count_q + 32'd1;
								end
							end
						end
					end
				end
				S_READ: begin
					if (rd_cnt_q == 3'(READ_STEPS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						rd_cnt_q <= rd_cnt_q + 3'd1;
					end
				end
				S_DRAIN: state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_MUL3;
				S_MUL3:  state_q <= S_DONE;
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Response payload; a rejected launch reports its verdict with zero counts.
	always_comb begin
		rsp_d        = '0;
		rsp_d.status = status_q;
		if (launch_q) begin
			rsp_d.command_start  = 1'b1;
			rsp_d.command_number = count_q;
			rsp_d.verdict        = c_verdict;
			if (c_verdict != VERDICT_REJECTED) begin
				rsp_d.resident_beats = c_res;
				rsp_d.input_beats    = c_inb;
				rsp_d.output_beats   = c_outb;
				rsp_d.work_items     = c_work;
				rsp_d.flow_stride    = c_fs;
				rsp_d.instr_stride   = c_is;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: design/cmdd_regfile.sv
// Register word memory of the CSR command decoder: one write port, one read port.
// Depends on cmdd_pkg.
`default_nettype none

module cmdd_regfile
	import cmdd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [WIDX_W-1:0] wr_addr,
	input  wire logic [63:0]       wr_data,
	input  wire logic              rd_en,
	input  wire logic [WIDX_W-1:0] rd_addr,
	output      logic [63:0]       rd_data
);

	logic [63:0]          mem [0:REG_WORDS-1];
	logic [REG_WORDS-1:0] valid_q;
	logic [63:0]          mem_q;
	logic                 rvld_q;

	// Entries read as zero until their first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	assign rd_data = rvld_q ? mem_q : '0;

endmodule

`default_nettype wire

// File: design/cmdd_calc.sv
// Field capture and multiply chain that decodes a launched command.
// Depends on cmdd_pkg; sequenced by the top level through calc_ctl_t.
`default_nettype none

module cmdd_calc
	import cmdd_pkg::*;
#(
	parameter int BEAT_BYTES = DEF_BEAT_BYTES
) (
	input  wire logic        clk,
	input  wire calc_ctl_t   ctl,
	input  wire logic [63:0] rd_data,
	output      logic [1:0]  verdict,
	output      logic [19:0] resident_beats,
	output      logic [17:0] input_beats,
	output      logic [17:0] output_beats,
	output      logic [23:0] work_items,
	output      logic [20:0] flow_stride,
	output      logic [28:0] instr_stride
);

	localparam logic [8:0] BB = 9'(BEAT_BYTES);

	logic [1:0]  verdict_q;
	logic [5:0]  loop_q;
	logic [5:0]  r_x_q, r_y_q, i_x_q, i_y_q, i_b_q, o_x_q, o_y_q, o_b_q;
	logic [7:0]  r_c_q, f_flow_q, f_y_q;
	logic [11:0] r_p_q, i_p_q, o_p_q;
	logic [15:0] f_p_q;
	logic [19:0] res_q;
	logic [17:0] inb_q, outb_q;
	logic [20:0] fs_q;
	logic [23:0] work_q;
	logic [24:0] fs_full;
	logic [1:0]  trans, regm, reuse, pe, flowm;
	logic [2:0]  conv;
	logic        reject, timed;

	always_comb begin
		trans  = rd_data[1:0];
		regm   = rd_data[3:2];
		reuse  = rd_data[5:4];
		pe     = rd_data[7:6];
		flowm  = rd_data[9:8];
		conv   = rd_data[12:10];
		reject = (pe != 2'd0) || rd_data[14] || (conv != 3'd0) || rd_data[13] ||
			(regm == REGM_BAD);
		timed  = ((trans == TRANS_ONE && flowm <= FLOWM_MAX) ||
			(trans == TRANS_TWO && flowm == 2'd0)) && (reuse == REUSE_ONE);
	end

	assign fs_full = 25'(f_p_q) * 25'(BB);

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			case (ctl.tag)
				WIDX_MODE: begin
					verdict_q <= reject ? VERDICT_REJECTED :
						(timed ? VERDICT_TIMED : VERDICT_UNTIMED);
					loop_q    <= rd_data[25:20];
				end
				WIDX_RES: begin
					r_x_q <= rd_data[37:32];
					r_y_q <= rd_data[51:46];
					r_c_q <= rd_data[31:24];
				end
				WIDX_IN: begin
					i_x_q <= rd_data[13:8];
					i_y_q <= rd_data[27:22];
					i_b_q <= rd_data[59:54];
				end
				WIDX_OUT: begin
					o_x_q <= rd_data[37:32];
					o_y_q <= rd_data[43:38];
					o_b_q <= rd_data[55:50];
				end
				WIDX_STEP: begin
					f_flow_q <= rd_data[39:32];
					f_y_q    <= rd_data[21:14];
				end
				default: begin
				end
			endcase
		end
		if (ctl.mul1) begin
			r_p_q <= 12'(r_x_q) * 12'(r_y_q);
			i_p_q <= 12'(i_x_q) * 12'(i_y_q);
			o_p_q <= 12'(o_x_q) * 12'(o_y_q);
			f_p_q <= 16'(f_flow_q) * 16'(f_y_q);
		end
		if (ctl.mul2) begin
			res_q  <= 20'(r_p_q) * 20'(r_c_q);
			inb_q  <= 18'(i_p_q) * 18'(i_b_q);
			outb_q <= 18'(o_p_q) * 18'(o_b_q);
			fs_q   <= fs_full[20:0];
		end
		if (ctl.mul3) begin
			work_q <= 24'(inb_q) * 24'(loop_q);
		end
	end

	assign verdict        = verdict_q;
	assign resident_beats = res_q;
	assign input_beats    = inb_q;
	assign output_beats   = outb_q;
	assign work_items     = work_q;
	assign flow_stride    = fs_q;
	// Any launch that is not rejected has a zero kernel field, so the stride is one beat.
	assign instr_stride   = 29'(BB);

endmodule

`default_nettype wire

// File: tb/sv/cmdd_checker.sv
// Response checker for the CSR command decoder: watches both channels,
// predicts each response from the accepted requests and compares field by field.
// Depends on cmdd_pkg for the request and response types and the status codes.
`default_nettype none

module cmdd_checker
	import cmdd_pkg::*;
#(
	parameter int DEVICE_NUMBER = DEF_DEVICE_NUMBER,
	parameter int BEAT_BYTES    = DEF_BEAT_BYTES
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	input  wire logic     req_stall,
	input  wire cmd_req_t req,
	input  wire logic     rsp_valid,
	input  wire logic     rsp_stall,
	input  wire cmd_rsp_t rsp,
	output int            fail_count,
	output int            pending,
	output int            checked,
	output int            timed,
	output int            untimed,
	output int            rejected,
	output int            refused
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] DEV_ID = 4'(DEVICE_NUMBER);

	// Shadow copy of the decoder state.
	logic [63:0] word_mem [REG_WORDS];
	logic        latch_q;
	logic [63:0] launch_stamp;
	logic        stamp_valid;
	logic [63:0] last_stamp;
	logic [31:0] launch_count;

	cmd_rsp_t expected_q [$];

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			flag_mismatch($sformatf("response %0d field %s is 0x%0h, predicted 0x%0h",
				checked, name, got, want));
		end
	endtask

	task automatic predict_response(input cmd_req_t r, output cmd_rsp_t e);
		logic [2:0]  widx;
		logic        arm;
		logic        fire;
		logic [63:0] w1, w2, w3, w4, w5;
		logic [1:0]  trans, regm, reuse, pe, flowm;
		logic [2:0]  conv;
		logic [63:0] resb, inb, outb, work, fstride, istride;
		e = '0;
		if (!r.accepted) begin
			e.status = STATUS_IGNORED;
		end else if (r.bus_address[7:4] != DEV_ID) begin
			e.status = STATUS_WRONGDEV;
		end else if (stamp_valid && r.write_cycle < last_stamp) begin
			e.status = STATUS_ORDER;
		end else begin
			// Any applied write with a later stamp releases the start latch.
			if (latch_q && r.write_cycle > launch_stamp)
				latch_q = 1'b0;
			stamp_valid = 1'b1;
			last_stamp  = r.write_cycle;
			widx = r.bus_address[3:1];
			if (widx == WIDX_NONE) begin
				e.status = STATUS_IDX7;
			end else begin
				e.status = STATUS_OK;
				word_mem[widx] = r.write_data;
				if (widx == WIDX_START) begin
					arm = (r.req_type[OP_SET] && (latch_q || r.write_data[31])) ||
						(r.req_type[OP_HOLD] && latch_q && r.write_data[31]);
					fire = !latch_q && arm;
					latch_q = arm;
					if (fire) begin
						launch_stamp = r.write_cycle;
						launch_count = launch_count + 32'd1;
						e.command_start  = 1'b1;
						e.command_number = launch_count;
						w1 = word_mem[WIDX_RES];
						w2 = word_mem[WIDX_IN];
						w3 = word_mem[WIDX_MODE];
						w4 = word_mem[WIDX_STEP];
						w5 = word_mem[WIDX_OUT];
						trans = w3[1:0];
						regm  = w3[3:2];
						reuse = w3[5:4];
						pe    = w3[7:6];
						flowm = w3[9:8];
						conv  = w3[12:10];
						if (pe != 2'd0 || w3[14] || conv != 3'd0 || w3[13] ||
								regm == REGM_BAD) begin
							e.verdict = VERDICT_REJECTED;
						end else begin
							if (((trans == TRANS_ONE && flowm <= FLOWM_MAX) ||
									(trans == TRANS_TWO && flowm == 2'd0)) &&
									reuse == REUSE_ONE)
								e.verdict = VERDICT_TIMED;
							else
								e.verdict = VERDICT_UNTIMED;
							resb = 64'(w1[37:32]) * 64'(w1[51:46]) * 64'(w1[31:24]);
							inb  = 64'(w2[13:8]) * 64'(w2[27:22]) * 64'(w2[59:54]);
							outb = 64'(w5[37:32]) * 64'(w5[43:38]) * 64'(w5[55:50]);
							work = inb * 64'(w3[25:20]);
							fstride = 64'(w4[39:32]) * 64'(w4[21:14]) * 64'(BEAT_BYTES);
							if (conv == 3'd0)
								istride = 64'(BEAT_BYTES);
							else
								istride = 64'(w4[55:48]) * fstride;
							e.resident_beats = resb[19:0];
							e.input_beats    = inb[17:0];
							e.output_beats   = outb[17:0];
							e.work_items     = work[23:0];
							e.flow_stride    = fstride[20:0];
							e.instr_stride   = istride[28:0];
						end
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cmd_rsp_t want;
		cmd_rsp_t pred;
		if (!arst_n) begin
			for (int i = 0; i < REG_WORDS; i++)
				word_mem[i] = '0;
			latch_q      = 1'b0;
			launch_stamp = '0;
			stamp_valid  = 1'b0;
			last_stamp   = '0;
			launch_count = '0;
			expected_q.delete();
			fail_count = 0;
			pending    = 0;
			checked    = 0;
			timed      = 0;
			untimed    = 0;
			rejected   = 0;
			refused    = 0;
		end else begin
			// Responses first, so a request taken in the same cycle never
			// stands in for a missing older one.
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					flag_mismatch("response with no request outstanding");
				end else begin
					want = expected_q.pop_front();
					check_field("status", rsp.status, want.status);
					check_field("command_start", rsp.command_start, want.command_start);
					check_field("command_number", rsp.command_number, want.command_number);
					check_field("verdict", rsp.verdict, want.verdict);
					check_field("resident_beats", rsp.resident_beats, want.resident_beats);
					check_field("input_beats", rsp.input_beats, want.input_beats);
					check_field("output_beats", rsp.output_beats, want.output_beats);
					check_field("work_items", rsp.work_items, want.work_items);
					check_field("flow_stride", rsp.flow_stride, want.flow_stride);
					check_field("instr_stride", rsp.instr_stride, want.instr_stride);
					checked++;
				end
			end
			if (req_valid && !req_stall) begin
				predict_response(req, pred);
				expected_q.insert(expected_q.size(), pred);
				if (pred.status != STATUS_OK)
					refused++;
				case (pred.verdict)
					VERDICT_TIMED:    timed++;
					VERDICT_UNTIMED:  untimed++;
					VERDICT_REJECTED: rejected++;
					default: ;
				endcase
			end
			pending = expected_q.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/accel_csr_command_decoder_top_tb.sv
// Testbench top for the CSR command decoder: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on cmdd_pkg, the
// decoder top level and the cmdd_checker module.
`default_nettype none

module accel_csr_command_decoder_top_tb
	import cmdd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEVICE_NUMBER = DEF_DEVICE_NUMBER;
	localparam int BEAT_BYTES    = DEF_BEAT_BYTES;
	localparam logic [3:0] DEV_ID = 4'(DEVICE_NUMBER);

	// Number of counted requests in the random part.
	localparam int RANDOM_REQUESTS = 400;
	// Extra cycles to run after the last response has come back.
	localparam int DRAIN_CYCLES = 32;
	// Longest correct wait between two handshakes is a launch plus a run of
	// stalls or idle cycles at 19 percent; this is far beyond that.
	localparam int QUIET_LIMIT = 2000;

	// Request type encodings, built from the bit positions in the package.
	localparam logic [1:0] REQ_PLAIN = 2'b00;
	localparam logic [1:0] REQ_SET   = 2'(1 << OP_SET);
	localparam logic [1:0] REQ_HOLD  = 2'(1 << OP_HOLD);
	localparam logic [1:0] REQ_BOTH  = REQ_SET | REQ_HOLD;

	// Word zero has no role in a launch; it is only stored.
	localparam logic [WIDX_W-1:0] WIDX_SPARE = 3'd0;

	// Flavors of the mode word (register word three) that steer the verdict.
	typedef enum int {MODE_ANY, MODE_TIMED, MODE_UNTIMED, MODE_REJECT} mode_kind_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	cmd_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	cmd_rsp_t rsp;

	int fail_count;
	int pending;
	int checked;
	int timed;
	int untimed;
	int rejected;
	int refused;

	int          idle_pct    = 19;
	int          stall_pct   = 19;
	int          items_sent  = 0;
	int          quiet_cycles = 0;
	logic [63:0] now_stamp   = '0;

	accel_csr_command_decoder_top #(
		.DEVICE_NUMBER(DEVICE_NUMBER),
		.BEAT_BYTES(BEAT_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	cmdd_checker #(
		.DEVICE_NUMBER(DEVICE_NUMBER),
		.BEAT_BYTES(BEAT_BYTES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked),
		.timed(timed),
		.untimed(untimed),
		.rejected(rejected),
		.refused(refused)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// The response side stalls at random; it changes only on the falling edge,
	// so the decoder sees a settled value at every rising edge.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// The watchdog counts cycles in which neither channel moves a request or
	// a response. Any handshake restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
			QUIET_LIMIT, pending);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Plain register data: mostly random, with the all-zero and all-one
	// corners now and then so the beat products reach their extremes.
	function automatic logic [63:0] data_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	// Builds a mode word of the requested flavor. The fields that do not
	// take part in the verdict (flow loop count and the upper bits) stay random.
	function automatic logic [63:0] mode_word(input mode_kind_t kind);
		logic [63:0] w;
		w = rand64();
		if (kind == MODE_ANY)
			return w;
		// Clear every operator-switch reason first.
		w[7:6]   = 2'b00;
		w[14:10] = 5'b00000;
		if (w[3:2] == REGM_BAD)
			w[3:2] = ~REGM_BAD;
		case (kind)
			MODE_TIMED: begin
				w[5:4] = REUSE_ONE;
				if ($urandom_range(1)) begin
					w[1:0] = TRANS_ONE;
					w[9:8] = 2'($urandom_range(FLOWM_MAX));
				end else begin
					w[1:0] = TRANS_TWO;
					w[9:8] = 2'b00;
				end
			end
			MODE_REJECT: begin
				case ($urandom_range(4))
					0: w[7:6] = 2'($urandom_range(3, 1));
					1: w[14] = 1'b1;
					2: w[12:10] = 3'($urandom_range(7, 1));
					3: w[13] = 1'b1;
					default: w[3:2] = REGM_BAD;
				endcase
			end
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [63:0] pick_mode();
		case ($urandom_range(9))
			0, 1, 2, 3: return mode_word(MODE_TIMED);
			4, 5, 6:    return mode_word(MODE_UNTIMED);
			7, 8:       return mode_word(MODE_REJECT);
			default:    return mode_word(MODE_ANY);
		endcase
	endfunction

	// Moves the bus cycle stamp forward. Repeated stamps are common on
	// purpose, since a strictly later stamp releases the start latch.
	function automatic logic [63:0] next_stamp();
		case ($urandom_range(9))
			0, 1: ;
			9: now_stamp = now_stamp + 64'($urandom_range(65535));
			default: now_stamp = now_stamp + 64'($urandom_range(4, 1));
		endcase
		return now_stamp;
	endfunction

	// Offers one request and holds it until the decoder takes it. Valid is
	// left high on return, so a back-to-back request is never dropped and
	// raised in the same time step; the next call lowers it if it idles.
	task automatic send(input cmd_req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
		if (r.accepted)
			items_sent++;
	endtask

	// One accepted write to this device. Address bit 0 is not decoded, so
	// it is left random.
	task automatic put(input logic [1:0] op, input logic [WIDX_W-1:0] widx,
			input logic [63:0] data, input logic [63:0] stamp);
		cmd_req_t r;
		r.accepted    = 1'b1;
		r.req_type    = op;
		r.bus_address = {DEV_ID, widx, 1'($urandom_range(1))};
		r.write_data  = data;
		r.write_cycle = stamp;
		send(r);
	endtask

	// A well-formed command: set up the operand words in a rotated order
	// (now and then one is skipped and keeps its old value), then write the
	// start word, biased toward a launch. Sometimes a second start write at
	// the same stamp follows, which exercises holding and dropping the latch.
	task automatic run_command();
		int              rot;
		logic [1:0]      op;
		logic [63:0]     data;
		logic [WIDX_W-1:0] widx;
		rot = $urandom_range(READ_STEPS - 1);
		for (int k = 0; k < READ_STEPS; k++) begin
			if ($urandom_range(9) < 8) begin
				widx = word_of_step(3'((k + rot) % READ_STEPS));
				data = (widx == WIDX_MODE) ? pick_mode() : data_word();
				put(2'($urandom_range(3)), widx, data, next_stamp());
			end
		end
		op = 2'($urandom_range(3));
		if ($urandom_range(9) < 7)
			op[OP_SET] = 1'b1;
		data = rand64();
		data[31] = ($urandom_range(9) < 8);
		put(op, WIDX_START, data, next_stamp());
		if ($urandom_range(9) < 3)
			put(2'($urandom_range(3)), WIDX_START, rand64(), now_stamp);
	endtask

	// Off-nominal traffic: ignored writes, other devices, stamps that go
	// backwards, word seven and loose writes to any word.
	task automatic run_noise();
		cmd_req_t r;
		logic [3:0] dev;
		r.accepted    = 1'b1;
		r.req_type    = 2'($urandom_range(3));
		r.bus_address = {DEV_ID, 4'($urandom_range(15))};
		r.write_data  = rand64();
		r.write_cycle = next_stamp();
		case ($urandom_range(5))
			0: begin
				r.accepted    = 1'b0;
				r.bus_address = 8'($urandom_range(255));
				r.write_cycle = rand64();
			end
			1: begin
				dev = 4'($urandom_range(15));
				if (dev == DEV_ID)
					dev = ~DEV_ID;
				r.bus_address[7:4] = dev;
				r.write_cycle = rand64();
			end
			2: begin
				if (now_stamp != '0)
					r.write_cycle = now_stamp - 64'd1 - (rand64() % now_stamp);
				else
					r.bus_address[3:1] = WIDX_NONE;
			end
			3: r.bus_address[3:1] = WIDX_NONE;
			4: begin
				r.bus_address[3:1] = WIDX_START;
				r.write_data[31] = 1'($urandom_range(1));
			end
			default: ;
		endcase
		send(r);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Ignored write with every field at its maximum.
		send('{accepted: 1'b0, req_type: '1, bus_address: '1, write_data: '1,
			write_cycle: '1});
		// Another device, with the largest stamp; it must not move the stamp.
		send('{accepted: 1'b1, req_type: '1, bus_address: {~DEV_ID, 4'hF},
			write_data: '1, write_cycle: '1});
		// Word seven at stamp zero: refused, but it starts stamp tracking.
		put(REQ_BOTH, WIDX_NONE, '1, 64'd0);
		// Operand words at their maximum and an accepted mode with the
		// largest flow loop count, then a launch: every count at its top.
		put(REQ_PLAIN, WIDX_RES, '1, 64'd1);
		put(REQ_PLAIN, WIDX_IN, '1, 64'd2);
		put(REQ_PLAIN, WIDX_OUT, '1, 64'd3);
		put(REQ_PLAIN, WIDX_STEP, '1, 64'd4);
		put(REQ_PLAIN, WIDX_MODE, mode_word(MODE_TIMED) | (64'h3F << 20), 64'd5);
		put(REQ_SET, WIDX_START, 64'h8000_0000, 64'd6);
		// Same stamp, so the latch stays up: hold keeps it, set keeps it,
		// a plain write drops it, and set without bit 31 cannot raise it.
		put(REQ_HOLD, WIDX_START, '1, 64'd6);
		put(REQ_SET, WIDX_START, 64'd0, 64'd6);
		put(REQ_PLAIN, WIDX_START, '1, 64'd6);
		put(REQ_SET, WIDX_START, 64'd0, 64'd6);
		// Rising again at the launch stamp is a second launch.
		put(REQ_BOTH, WIDX_START, 64'h8000_0000, 64'd6);
		// A later stamp on word zero releases the latch; then a stamp
		// that goes backwards is refused.
		put(REQ_PLAIN, WIDX_SPARE, '1, 64'd7);
		put(REQ_PLAIN, WIDX_RES, '0, 64'd3);
		// All-zero mode word: legal but untimed.
		put(REQ_PLAIN, WIDX_MODE, '0, 64'd8);
		put(REQ_SET, WIDX_START, 64'h8000_0000, 64'd9);
		// Operator switch rejected by PE mode, by the kernel field and by
		// the register mode.
		put(REQ_PLAIN, WIDX_MODE, mode_word(MODE_TIMED) | (64'h3 << 6), 64'd10);
		put(REQ_SET, WIDX_START, 64'h8000_0000, 64'd11);
		put(REQ_PLAIN, WIDX_MODE, mode_word(MODE_TIMED) | (64'h7 << 10), 64'd12);
		put(REQ_SET, WIDX_START, 64'h8000_0000, 64'd13);
		put(REQ_PLAIN, WIDX_MODE,
			(mode_word(MODE_TIMED) & ~(64'h3 << 2)) | (64'(REGM_BAD) << 2), 64'd14);
		put(REQ_SET, WIDX_START, 64'h8000_0000, 64'd15);
		now_stamp = 64'd15;

		// Random part: mostly complete commands, the rest off-nominal.
		// A stretch in the middle runs with no idling on either side.
		items_sent = 0;
		while (items_sent < RANDOM_REQUESTS) begin
			if (items_sent >= 180 && items_sent < 280) begin
				idle_pct  = 0;
				stall_pct = 0;
			end else begin
				idle_pct  = 19;
				stall_pct = 19;
			end
			if ($urandom_range(9) < 7)
				run_command();
			else
				run_noise();
		end

		// Close with a launch at the largest stamp and a write just below it.
		put(REQ_SET, WIDX_START, '1, '1);
		put(REQ_PLAIN, WIDX_RES, '1, 64'hFFFF_FFFF_FFFF_FFFE);

		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d responses; %0d writes were refused or ignored.",
			checked, refused);
		$display("Launches seen: %0d timed, %0d untimed, %0d rejected by the operator check.",
			timed, untimed, rejected);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
